FILE: rtl/lert_pkg.sv
package lert_pkg;

  // input opcodes
  typedef enum logic [2:0] {
    OP_PLAY    = 3'd0,
    OP_TICK    = 3'd1,
    OP_SETVOL  = 3'd2,
    OP_STOP    = 3'd3,
    OP_STOPALL = 3'd4
  } op_t;

  // result actions
  typedef enum logic [2:0] {
    ACT_PLAY_ONCE  = 3'd0,
    ACT_LOOP_START = 3'd1,
    ACT_RETRIGGER  = 3'd2,
    ACT_SET_VOLUME = 3'd3,
    ACT_UNLOAD     = 3'd4,
    ACT_CANCEL_ALL = 3'd5,
    ACT_TABLE_FULL = 3'd6
  } act_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN2,
    ST_FLUSH
  } state_t;

  // one table entry, held by one cell
  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] period;
    logic [15:0] countdown;
    logic [7:0]  volume;
  } entry_t;

  // control flags from the sequencer to the head unit
  typedef struct packed {
    op_t  op;
    logic pass2;
    logic in_range;
    logic at_target;
    logic at_top;
    logic found;
    logic target_is_top;
  } head_ctl_t;

  // what the head unit reports for the entry passing it
  typedef struct packed {
    logic        produce;
    logic        hit;
    act_t        act;
    logic [15:0] smp;
    logic [7:0]  vol;
  } head_res_t;

  // one result word
  typedef struct packed {
    act_t        act;
    logic [15:0] smp;
    logic [7:0]  vol;
    logic [3:0]  cnt;
  } res_t;

endpackage

FILE: rtl/lert_cell.sv
module lert_cell
  import lert_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  entry_t d_in,
  output entry_t q
);

  entry_t entry_r;

  // take the neighbor's entry on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d_in;
    end
  end

  assign q = entry_r;

endmodule

FILE: rtl/lert_head.sv
module lert_head
  import lert_pkg::*;
(
  input  head_ctl_t   ctl,
  input  entry_t      cur,
  input  entry_t      wr_entry,
  input  entry_t      top_entry,
  input  logic [15:0] key,
  input  logic [7:0]  vol,
  output entry_t      d_out,
  output head_res_t   res
);

  logic key_match;

  assign key_match = ctl.in_range && !ctl.found && (cur.sample == key);

  // update the entry at the head of the ring and report any result
  always_comb begin
    d_out = cur;
    res   = '0;
    unique case (ctl.op)
      OP_PLAY: begin
        if (ctl.at_target) begin
          d_out = wr_entry;
        end
      end
      OP_TICK: begin
        if (ctl.in_range && (cur.countdown != 16'd0)) begin
          if (cur.countdown == 16'd1) begin
            d_out.countdown = cur.period;
            res.produce     = 1'b1;
            res.act         = ACT_RETRIGGER;
            res.smp         = cur.sample;
            res.vol         = cur.volume;
          end else begin
            d_out.countdown = cur.countdown - 16'd1;
          end
        end
      end
      OP_SETVOL: begin
        if (key_match) begin
          d_out.volume = vol;
          res.produce  = 1'b1;
          res.hit      = 1'b1;
          res.act      = ACT_SET_VOLUME;
          res.smp      = key;
          res.vol      = vol;
        end
      end
      OP_STOP: begin
        if (!ctl.pass2) begin
          res.hit = key_match;
        end else if (ctl.at_target) begin
          d_out = ctl.target_is_top ? '0 : top_entry;
        end else if (ctl.at_top) begin
          d_out = '0;
        end
      end
      default: begin
        d_out = cur;
      end
    endcase
  end

endmodule

FILE: rtl/looped_effect_retrigger_table.sv
// channel   direction  handshake          fields
// input     in         start / busy       in_opcode .. in_volume_in, five fields
// result    out        out_valid strobe   out_action .. out_last, five fields
//
// entries sit in a ring of MAX_ENTRIES cells that rotates one place per cycle while a
// pass is under way, past a single head unit; a pass visits every cell once
// one-shot play, table full, stop all: no pass, the word comes from the flush state
// looping play, tick, set volume, stop without match: one pass over the table
// stop with a match takes a second pass to move the top entry
// busy is high until the last word has been registered; results cannot be stalled
// reset (rst_n low, synchronous) empties the table and drops any pending word
module looped_effect_retrigger_table
  import lert_pkg::*;
#(
  parameter int MAX_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_sample_id,
  input  logic        in_loop_flag,
  input  logic [15:0] in_period_ticks,
  input  logic [7:0]  in_volume_in,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [15:0] out_sample_out,
  output logic [7:0]  out_volume_out,
  output logic [3:0]  out_entry_count_out,
  output logic        out_last
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  op_t              op_r, op_nxt;
  logic [15:0]      key_r, key_nxt;
  logic [7:0]       vol_r, vol_nxt;
  entry_t           wr_r, wr_nxt;
  entry_t           top_r, top_nxt;
  res_t             pend_r, pend_nxt;
  res_t             out_r, out_nxt;

  entry_t           cell_q [MAX_ENTRIES];
  entry_t           head_d;
  head_ctl_t        hctl;
  head_res_t        hres;

  logic             scanning;
  logic             last_step;
  logic             in_range;
  logic             at_top_p1;
  logic             found_now;
  logic             table_full;
  logic [3:0]       cnt4;

  // ring of cells, the head unit feeds the far end
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t d_in;
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign d_in = head_d;
    end else begin : g_link
      assign d_in = cell_q[i+1];
    end
    lert_cell u_cell (
      .clk      (clk),
      .shift_en (scanning),
      .d_in     (d_in),
      .q        (cell_q[i])
    );
  end

  // position flags for the entry now at the head
  assign scanning   = (state_r == ST_SCAN) || (state_r == ST_SCAN2);
  assign last_step  = (step_r == IDX_W'(MAX_ENTRIES - 1));
  assign in_range   = (CNT_W'(step_r) < count_r);
  assign at_top_p1  = (CNT_W'(step_r) + CNT_W'(1) == count_r);
  assign found_now  = found_r || hres.hit;
  assign table_full = (count_r == CNT_W'(MAX_ENTRIES));
  assign cnt4       = 4'(count_r);

  assign hctl.op            = op_r;
  assign hctl.pass2         = (state_r == ST_SCAN2);
  assign hctl.in_range      = in_range;
  assign hctl.at_target     = (step_r == idx_r);
  assign hctl.at_top        = (CNT_W'(step_r) == count_r);
  assign hctl.found         = found_r;
  assign hctl.target_is_top = (CNT_W'(idx_r) == count_r);

  lert_head u_head (
    .ctl       (hctl),
    .cur       (cell_q[0]),
    .wr_entry  (wr_r),
    .top_entry (top_r),
    .key       (key_r),
    .vol       (vol_r),
    .d_out     (head_d),
    .res       (hres)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_opcode)
            OP_PLAY: begin
              state_nxt = (in_loop_flag && !table_full) ? ST_SCAN : ST_FLUSH;
            end
            OP_TICK, OP_SETVOL, OP_STOP: state_nxt = ST_SCAN;
            OP_STOPALL: state_nxt = ST_FLUSH;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          if (op_r == OP_STOP) begin
            state_nxt = found_now ? ST_SCAN2 : ST_FLUSH;
          end else begin
            state_nxt = (pend_valid_r || hres.produce) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_SCAN2: begin
        if (last_step) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    step_nxt       = step_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_last_nxt   = 1'b0;
    out_nxt        = out_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    vol_nxt        = vol_r;
    wr_nxt         = wr_r;
    top_nxt        = top_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          step_nxt  = '0;
          found_nxt = 1'b0;
          key_nxt   = in_sample_id;
          vol_nxt   = in_volume_in;
          wr_nxt    = '{sample: in_sample_id, period: in_period_ticks,
                        countdown: in_period_ticks, volume: in_volume_in};
          unique case (in_opcode)
            OP_PLAY: begin
              op_nxt         = OP_PLAY;
              pend_valid_nxt = 1'b1;
              if (!in_loop_flag) begin
                pend_nxt = '{act: ACT_PLAY_ONCE, smp: in_sample_id,
                             vol: in_volume_in, cnt: cnt4};
              end else if (table_full) begin
                pend_nxt = '{act: ACT_TABLE_FULL, smp: in_sample_id,
                             vol: 8'd0, cnt: cnt4};
              end else begin
                idx_nxt   = IDX_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
                pend_nxt  = '{act: ACT_LOOP_START, smp: in_sample_id,
                              vol: 8'd0, cnt: 4'(count_r + CNT_W'(1))};
              end
            end
            OP_TICK:   op_nxt = OP_TICK;
            OP_SETVOL: op_nxt = OP_SETVOL;
            OP_STOP:   op_nxt = OP_STOP;
            OP_STOPALL: begin
              op_nxt         = OP_STOPALL;
              count_nxt      = '0;
              pend_valid_nxt = 1'b1;
              pend_nxt       = '{act: ACT_CANCEL_ALL, smp: 16'd0, vol: 8'd0, cnt: 4'd0};
            end
            default: op_nxt = op_r;
          endcase
        end
      end
      ST_SCAN: begin
        step_nxt = last_step ? '0 : step_r + IDX_W'(1);
        // a new word pushes the pending one out, which is then not the last
        if (hres.produce) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_valid_nxt = 1'b1;
          pend_nxt       = '{act: hres.act, smp: hres.smp, vol: hres.vol, cnt: cnt4};
        end
        if (hres.hit && !found_r) begin
          found_nxt = 1'b1;
          idx_nxt   = step_r;
        end
        // stop: remember the top entry and settle the count
        if ((op_r == OP_STOP) && in_range && at_top_p1) begin
          top_nxt = cell_q[0];
        end
        if (last_step && (op_r == OP_STOP)) begin
          pend_valid_nxt = 1'b1;
          if (found_now) begin
            count_nxt = count_r - CNT_W'(1);
            pend_nxt  = '{act: ACT_UNLOAD, smp: key_r, vol: 8'd0,
                          cnt: 4'(count_r - CNT_W'(1))};
          end else begin
            pend_nxt  = '{act: ACT_UNLOAD, smp: key_r, vol: 8'd0, cnt: cnt4};
          end
        end
      end
      ST_SCAN2: begin
        step_nxt = last_step ? '0 : step_r + IDX_W'(1);
      end
      ST_FLUSH: begin
        out_valid_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
        out_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      count_r      <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      count_r      <= count_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    vol_r      <= vol_nxt;
    wr_r       <= wr_nxt;
    top_r      <= top_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // ports
  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_action          = out_r.act;
  assign out_sample_out      = out_r.smp;
  assign out_volume_out      = out_r.vol;
  assign out_entry_count_out = out_r.cnt;
  assign out_last            = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_flush_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> pend_valid_r)
    else $error("flush without a pending word");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending word left behind in idle");

  a_last_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> $past(state_r == ST_FLUSH))
    else $error("final word not from flush");

  a_pass2_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN2) |-> (count_r < CNT_W'(MAX_ENTRIES)))
    else $error("second stop pass with full count");

endmodule
